// ===== hdl/cfa_pkg.sv =====
`default_nettype none

package cfa_pkg;

  // Frame store geometry.
  localparam int FRAME_WORDS = 32;
  localparam int IDX_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int CNT_W = $clog2(FRAME_WORDS + 1);

  // Job queue between the front and back parts (depth is a power of two).
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Line constants.
  localparam logic [15:0] END_MARK = 16'hffff;
  localparam logic [15:0] ZERO_WORD = 16'h0000;
  localparam logic [4:0] POLL_CODE = 5'h01;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  // Request commands.
  localparam logic [1:0] CMD_WORD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Job operations.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_WORD = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;
  localparam logic [1:0] OP_EVENT = 2'd3;

  // Result kinds.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_IDLE_POLL = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_WANT_IDLE_POLLS = 1'b0;
  localparam logic REG_PAIR_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [15:0] line_word;
    logic [47:0] now_us;
  } in_t;

  typedef struct packed {
    logic kind;
    logic [15:0] out_word;
    logic from_terminal;
    logic rx_error;
    logic frame_last;
    logic [47:0] stamp_us;
  } out_t;

  typedef struct packed {
    logic want_idle_polls;
    logic [15:0] pair_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] word;
    logic [CNT_W-1:0] count;
    logic term;
    logic err;
    logic [47:0] stamp;
  } job_t;

  typedef struct packed {
    logic avail;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/cfa_queue.sv =====
`default_nettype none

module cfa_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cfa_pkg::job_t  push_job,
  input  wire logic           pop,
  output cfa_pkg::job_t       head,
  output cfa_pkg::q_stat_t    stat
);
  import cfa_pkg::*;

  job_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0] fill;

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  assign head = slots[rd_ptr];
  assign stat.avail = (fill != '0);
  assign stat.full = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== hdl/cfa_front.sv =====
`default_nettype none

module cfa_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cfa_pkg::in_t     in_data,
  input  wire cfa_pkg::cfg_t    cfg,
  input  wire cfa_pkg::q_stat_t q_stat,
  output logic                  push,
  output cfa_pkg::job_t         push_job
);
  import cfa_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [15:0] first_word;
  logic [15:0] first_word_next;
  logic poll_held;
  logic poll_held_next;
  logic [15:0] held_word;
  logic [15:0] held_word_next;
  logic [47:0] held_time;
  logic [47:0] held_time_next;
  logic pend_valid;
  job_t pend_job;

  logic acc;
  logic [47:0] diff;
  logic in_window;
  logic stale;
  logic do_finish;
  logic fin_err;
  logic pair;
  logic hold;
  logic a_valid;
  logic b_valid;
  job_t job_a;
  job_t job_b;
  job_t frame_job;

  function automatic job_t word_job(input logic [15:0] w, input logic [47:0] stamp);
    job_t j;
    j = '0;
    j.op = OP_WORD;
    j.word = w;
    j.term = ~w[0];
    j.stamp = stamp;
    return j;
  endfunction

  function automatic logic is_poll(input logic [15:0] w);
    return w[0] && (w[6:2] == POLL_CODE);
  endfunction

  assign acc = in_valid && in_ready;
  assign in_ready = !pend_valid && !q_stat.full;

  // Age of the held poll, modulo 2^48, against the pairing window.
  assign diff = in_data.now_us - held_time;
  assign in_window = (diff[47:16] == '0) && (diff[15:0] < cfg.pair_timeout_us);
  assign stale = (diff[47:16] != '0) || (diff[15:0] > cfg.pair_timeout_us);

  // Classify the request and build up to two jobs for the back part.
  always_comb begin
    count_next = count;
    first_word_next = first_word;
    poll_held_next = poll_held;
    held_word_next = held_word;
    held_time_next = held_time;
    a_valid = 1'b0;
    b_valid = 1'b0;
    job_a = '0;
    job_b = '0;
    do_finish = 1'b0;
    fin_err = 1'b0;
    pair = 1'b0;
    hold = 1'b0;

    frame_job = '0;
    frame_job.op = OP_FRAME;
    frame_job.count = count;
    frame_job.term = ~first_word[0];
    frame_job.stamp = in_data.now_us;

    if (acc) begin
      case (in_data.cmd)
        CMD_WORD: begin
          if (in_data.line_word == END_MARK) begin
            do_finish = 1'b1;
          end else if (count < CNT_W'(FRAME_WORDS)) begin
            a_valid = 1'b1;
            job_a.op = OP_WRITE;
            job_a.count = count;
            job_a.word = in_data.line_word;
            if (count == '0) begin
              first_word_next = in_data.line_word;
            end
            count_next = count + 1'b1;
          end else begin
            do_finish = 1'b1;
            fin_err = 1'b1;
          end
        end
        CMD_TICK: begin
          if (poll_held && stale) begin
            a_valid = 1'b1;
            job_a = word_job(held_word, held_time);
            poll_held_next = 1'b0;
          end
        end
        CMD_RESTART: begin
          count_next = '0;
          poll_held_next = 1'b0;
        end
        default: begin
        end
      endcase
    end

    frame_job.err = fin_err;

    // Frame end: pair with a held poll, else release it, then hold a new poll or emit the frame.
    if (do_finish && (count != '0)) begin
      count_next = '0;
      pair = poll_held && (count == CNT_W'(1)) && (first_word == ZERO_WORD) && in_window;
      if (pair) begin
        poll_held_next = 1'b0;
        a_valid = 1'b1;
        if (cfg.want_idle_polls) begin
          job_a = word_job(held_word, held_time);
          b_valid = 1'b1;
          job_b = word_job(ZERO_WORD, in_data.now_us);
        end else begin
          job_a = '0;
          job_a.op = OP_EVENT;
          job_a.stamp = in_data.now_us;
        end
      end else begin
        hold = (count == CNT_W'(1)) && is_poll(first_word) && !fin_err;
        poll_held_next = hold;
        if (hold) begin
          held_word_next = first_word;
          held_time_next = in_data.now_us;
        end
        if (poll_held) begin
          a_valid = 1'b1;
          job_a = word_job(held_word, held_time);
          b_valid = !hold;
          job_b = frame_job;
        end else begin
          a_valid = !hold;
          job_a = frame_job;
        end
      end
    end
  end

  // The second job of a request waits here until the queue has room.
  assign push = a_valid || (pend_valid && !q_stat.full);
  assign push_job = pend_valid ? pend_job : job_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      poll_held <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      count <= count_next;
      poll_held <= poll_held_next;
      if (acc) begin
        pend_valid <= b_valid;
      end else if (pend_valid && !q_stat.full) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_word <= first_word_next;
    held_word <= held_word_next;
    held_time <= held_time_next;
    if (acc) begin
      pend_job <= job_b;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cfa_back.sv =====
`default_nettype none

module cfa_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfa_pkg::job_t    head,
  input  wire cfa_pkg::q_stat_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cfa_pkg::out_t         out_data
);
  import cfa_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;

  logic [15:0] mem [FRAME_WORDS];
  logic [15:0] rd_data;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [CNT_W-1:0] f_cnt;
  logic f_err;
  logic f_term;
  logic [47:0] f_stamp;

  logic out_free;
  logic mem_we;
  logic load;
  logic frame_start;
  logic at_last;
  out_t load_data;

  assign out_free = !out_valid || out_ready;
  assign at_last = ((CNT_W'(idx) + 1'b1) == f_cnt);

  // Job sequencer: store writes, single results, and frame streaming.
  always_comb begin
    state_next = state;
    idx_next = idx;
    pop = 1'b0;
    mem_we = 1'b0;
    load = 1'b0;
    frame_start = 1'b0;
    load_data.kind = (head.op == OP_EVENT) ? KIND_IDLE_POLL : KIND_FRAME;
    load_data.out_word = head.word;
    load_data.from_terminal = head.term;
    load_data.rx_error = head.err;
    load_data.frame_last = 1'b1;
    load_data.stamp_us = head.stamp;

    case (state)
      B_IDLE: begin
        if (q_stat.avail) begin
          case (head.op)
            OP_WRITE: begin
              mem_we = 1'b1;
              pop = 1'b1;
            end
            OP_WORD, OP_EVENT: begin
              if (out_free) begin
                load = 1'b1;
                pop = 1'b1;
              end
            end
            OP_FRAME: begin
              frame_start = 1'b1;
              pop = 1'b1;
              idx_next = '0;
              state_next = B_READ;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        state_next = B_LOAD;
      end
      B_LOAD: begin
        load_data.kind = KIND_FRAME;
        load_data.out_word = rd_data;
        load_data.from_terminal = f_term;
        load_data.rx_error = f_err;
        load_data.frame_last = at_last;
        load_data.stamp_us = f_stamp;
        if (out_free) begin
          load = 1'b1;
          if (at_last) begin
            state_next = B_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Frame store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDX_W'(head.count)] <= head.word;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (load) begin
      out_data <= load_data;
    end
    if (frame_start) begin
      f_cnt <= head.count;
      f_err <= head.err;
      f_term <= head.term;
      f_stamp <= head.stamp;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/coax_frame_assembler_poll_filter_core.sv =====
// A single-word result or an idle-poll event passes through the job queue and the output
// register; the first streamed frame word also passes through the read and load states,
// behind any released poll. Throughput: one request per cycle while the four-entry job
// queue has room; a request that causes two jobs holds the input until its second job is
// in the queue. The back part emits a single result per cycle while the output is not
// stalled, and streams each frame word through a read and a load state, as the frame store
// read is registered. Reset (rst, synchronous) clears the frame, the held poll, the queue and
// the output, and returns the registers to their defaults; no clearing pass follows.
`default_nettype none

module coax_frame_assembler_poll_filter_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cfa_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output cfa_pkg::out_t      out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cfa_pkg::*;

  cfg_t cfg;
  q_stat_t q_stat;
  logic push;
  logic pop;
  job_t push_job;
  job_t head;
  logic reg_sel;
  logic wr_en;

  // Configuration registers, one per word address.
  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.want_idle_polls <= 1'b0;
      cfg.pair_timeout_us <= TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WANT_IDLE_POLLS: cfg.want_idle_polls <= pwdata[0];
        REG_PAIR_TIMEOUT: cfg.pair_timeout_us <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WANT_IDLE_POLLS: prdata = {31'd0, cfg.want_idle_polls};
      REG_PAIR_TIMEOUT: prdata = {16'd0, cfg.pair_timeout_us};
      default: prdata = '0;
    endcase
  end

  cfa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  cfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  cfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/cfa_frame_check.sv =====
module cfa_frame_check (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_ready,
  input  wire cfa_pkg::in_t  in_data,
  input  wire logic          out_valid,
  input  wire logic          out_ready,
  input  wire cfa_pkg::out_t out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  input  wire logic          pready,
  output int                 mismatches,
  output int                 waiting,
  output int                 results_seen,
  output int                 idle_events,
  output int                 cut_frames
);
  import cfa_pkg::*;

  // Our own copy of the assembler state and its two registers.
  logic [15:0] frame_buf [FRAME_WORDS];
  int unsigned frame_fill;
  logic        poll_parked;
  logic [15:0] parked_word;
  logic [47:0] parked_stamp;
  logic        emit_idle_pairs;
  logic [15:0] pairing_window;

  // Results still owed by the block, oldest first.
  out_t        expected_words [$];

  initial begin
    mismatches = 0;
    results_seen = 0;
    idle_events = 0;
    cut_frames = 0;
  end

  task automatic note_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
  endtask

  function automatic void expect_word(input logic kind, input logic [15:0] w,
                                      input logic term, input logic err,
                                      input logic last, input logic [47:0] stamp);
    out_t r;
    r.kind = kind;
    r.out_word = w;
    r.from_terminal = term;
    r.rx_error = err;
    r.frame_last = last;
    r.stamp_us = stamp;
    expected_words.push_back(r);
  endfunction

  // A held poll goes out as a one-word frame with its own stamp.
  function automatic void release_held_poll();
    if (!poll_parked) return;
    poll_parked = 1'b0;
    expect_word(KIND_FRAME, parked_word, ~parked_word[0], 1'b0, 1'b1,
                parked_stamp);
  endfunction

  // Closes the collected frame: pair it with a held poll, or release any held poll and then
  // hold it as a poll or emit it word by word.
  function automatic void close_frame(input logic err, input logic [47:0] now);
    logic [47:0] gap;
    int unsigned i;
    if (frame_fill == 0) return;
    gap = now - parked_stamp;
    if (poll_parked && frame_fill == 1 && frame_buf[0] == ZERO_WORD &&
        gap < {32'd0, pairing_window}) begin
      if (emit_idle_pairs) begin
        release_held_poll();
        expect_word(KIND_FRAME, ZERO_WORD, 1'b1, 1'b0, 1'b1, now);
      end else begin
        poll_parked = 1'b0;
        expect_word(KIND_IDLE_POLL, ZERO_WORD, 1'b0, 1'b0, 1'b1, now);
      end
      frame_fill = 0;
      return;
    end
    release_held_poll();
    if (frame_fill == 1 && frame_buf[0][0] && frame_buf[0][6:2] == POLL_CODE && !err) begin
      poll_parked = 1'b1;
      parked_word = frame_buf[0];
      parked_stamp = now;
      frame_fill = 0;
      return;
    end
    for (i = 0; i < frame_fill; i++) begin
      expect_word(KIND_FRAME, frame_buf[i], ~frame_buf[0][0], err, (i + 1 == frame_fill),
                  now);
    end
    frame_fill = 0;
  endfunction

  // Works out what one accepted request owes.
  function automatic void predict(input in_t req);
    logic [47:0] gap;
    case (req.cmd)
      CMD_WORD: begin
        if (req.line_word == END_MARK) begin
          close_frame(1'b0, req.now_us);
        end else if (frame_fill < FRAME_WORDS) begin
          frame_buf[frame_fill] = req.line_word;
          frame_fill++;
        end else begin
          // The overflowing word is lost; the frame goes out flagged.
          close_frame(1'b1, req.now_us);
        end
      end
      CMD_TICK: begin
        gap = req.now_us - parked_stamp;
        if (poll_parked && gap > {32'd0, pairing_window}) begin
          release_held_poll();
        end
      end
      CMD_RESTART: begin
        frame_fill = 0;
        poll_parked = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic compare_result(input out_t got);
    out_t want;
    if (expected_words.size() == 0) begin
      note_mismatch("result with nothing outstanding, out_word", 48'(got.out_word), '0);
      return;
    end
    want = expected_words.pop_front();
    results_seen++;
    if (got.kind == KIND_IDLE_POLL) idle_events++;
    if (got.frame_last && got.rx_error) cut_frames++;
    if (got.kind != want.kind) note_mismatch("kind", 48'(got.kind), 48'(want.kind));
    if (got.out_word != want.out_word) begin
      note_mismatch("out_word", 48'(got.out_word), 48'(want.out_word));
    end
    if (got.from_terminal != want.from_terminal) begin
      note_mismatch("from_terminal", 48'(got.from_terminal), 48'(want.from_terminal));
    end
    if (got.rx_error != want.rx_error) begin
      note_mismatch("rx_error", 48'(got.rx_error), 48'(want.rx_error));
    end
    if (got.frame_last != want.frame_last) begin
      note_mismatch("frame_last", 48'(got.frame_last), 48'(want.frame_last));
    end
    if (got.stamp_us != want.stamp_us) note_mismatch("stamp_us", got.stamp_us, want.stamp_us);
  endtask

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin
    if (rst) begin
      frame_fill = 0;
      poll_parked = 1'b0;
      parked_word = ZERO_WORD;
      parked_stamp = '0;
      emit_idle_pairs = 1'b0;
      pairing_window = TIMEOUT_RESET;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PAIR_TIMEOUT) begin
          pairing_window = pwdata[15:0];
        end else begin
          emit_idle_pairs = pwdata[0];
        end
      end
      if (out_valid && out_ready) compare_result(out_data);
      if (in_valid && in_ready) predict(in_data);
    end
    waiting <= expected_words.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import cfa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;
  // The block ignores this command code.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int waiting;
  int results_seen;
  int idle_events;
  int cut_frames;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count = 0;
  logic [47:0] stim_us = 48'd5000;
  logic [47:0] poll_sent_us = '0;
  logic [15:0] window_us = TIMEOUT_RESET;

  coax_frame_assembler_poll_filter_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cfa_frame_check frame_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .waiting(waiting), .results_seen(results_seen),
    .idle_events(idle_events), .cut_frames(cut_frames)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(input logic [1:0] cmd, input logic [15:0] word,
                              input logic [47:0] at_us);
    in_t req;
    req.cmd = cmd;
    req.line_word = word;
    req.now_us = at_us;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  // A one-word frame: the word and its end marker with the same time stamp.
  task automatic send_single(input logic [15:0] word, input logic [47:0] at_us);
    send_request(CMD_WORD, word, at_us);
    send_request(CMD_WORD, END_MARK, at_us);
  endtask

  // Stops sending and waits until every owed result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic want, input logic [15:0] window);
    drain();
    write_reg(REG_WANT_IDLE_POLLS, {31'd0, want});
    write_reg(REG_PAIR_TIMEOUT, {16'd0, window});
    window_us = window;
  endtask

  function automatic logic [15:0] make_poll();
    logic [15:0] w;
    w = 16'($urandom);
    w[6:2] = POLL_CODE;
    w[0] = 1'b1;
    return w;
  endfunction

  function automatic logic [15:0] any_line_word();
    return 16'($urandom_range(0, 32'hfffe));
  endfunction

  // Distance from the held poll, mostly close to the pairing window.
  function automatic logic [47:0] gap_near();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 48'(window_us) + 48'($urandom_range(4)) - 48'd2;
    else if (r < 8) return 48'($urandom_range(0, window_us));
    else if (r < 9) return 48'(window_us) + 48'($urandom_range(1, 5000));
    else return 48'($urandom_range(0, 20));
  endfunction

  function automatic void advance();
    stim_us = stim_us + 48'($urandom_range(1, 40));
  endfunction

  // Mostly well-formed frames, polls and answers, with some noise mixed in.
  task automatic random_traffic(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned i;
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if ($urandom_range(32) == 0) stim_us = {16'($urandom), $urandom};
      if (pick < 38) begin
        len = ($urandom_range(11) == 0) ? $urandom_range(31, 34) : $urandom_range(1, 5);
        for (i = 0; i < len; i++) begin
          advance();
          send_request(CMD_WORD, any_line_word(), stim_us);
        end
        advance();
        send_request(CMD_WORD, END_MARK, stim_us);
      end else if (pick < 60) begin
        advance();
        send_single(make_poll(), stim_us);
        poll_sent_us = stim_us;
        // Most polls are followed at once by an answer or a tick.
        len = $urandom_range(3);
        if (len < 2) begin
          stim_us = poll_sent_us + gap_near();
          send_single(ZERO_WORD, stim_us);
        end else if (len == 2) begin
          stim_us = poll_sent_us + gap_near();
          send_request(CMD_TICK, 16'($urandom), stim_us);
        end
      end else if (pick < 72) begin
        stim_us = poll_sent_us + gap_near();
        send_single(ZERO_WORD, stim_us);
      end else if (pick < 80) begin
        stim_us = poll_sent_us + gap_near();
        send_request(CMD_TICK, 16'($urandom), stim_us);
      end else if (pick < 87) begin
        len = $urandom_range(0, 3);
        for (i = 0; i < len; i++) begin
          advance();
          send_request(CMD_WORD, any_line_word(), stim_us);
        end
        send_request(CMD_RESTART, 16'($urandom), stim_us);
      end else if (pick < 90) begin
        send_request(CMD_UNUSED, 16'($urandom), {16'($urandom), $urandom});
      end else begin
        advance();
        send_request(CMD_WORD, 16'($urandom), stim_us);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases under the reset settings: events counted, window 2000.
    // A poll answered inside the window becomes one idle-poll event.
    send_single(16'h0005, 48'd5000);
    send_single(ZERO_WORD, 48'd6999);
    // An answer exactly at the window releases the poll and emits the zero frame.
    send_single(16'hff87, 48'd8000);
    send_single(ZERO_WORD, 48'd10000);
    // A tick at the window keeps the poll; one microsecond later releases it.
    send_single(16'h0007, 48'd12000);
    send_request(CMD_TICK, ZERO_WORD, 48'd14000);
    send_request(CMD_TICK, END_MARK, 48'd14001);
    // An empty frame and the unused command produce nothing.
    send_request(CMD_WORD, END_MARK, 48'd14002);
    send_request(CMD_UNUSED, 16'h5a5a, 48'hffff_ffff_ffff);
    // A terminal frame with extreme words.
    send_request(CMD_WORD, 16'hfffe, 48'd14010);
    send_request(CMD_WORD, ZERO_WORD, 48'd14011);
    send_request(CMD_WORD, END_MARK, 48'd14012);
    // Restart drops both the partial frame and the held poll.
    send_single(16'h0005, 48'd15000);
    send_request(CMD_WORD, 16'h1234, 48'd15001);
    send_request(CMD_RESTART, 16'hffff, 48'd15002);
    send_single(ZERO_WORD, 48'd15003);
    // Pairing across the wrap of the microsecond counter.
    send_single(16'h0005, 48'hffff_ffff_fff0);
    send_single(ZERO_WORD, 48'h0000_0000_0010);
    stim_us = 48'd20000;

    configure(1'b1, TIMEOUT_RESET);
    send_idle_pct = 62;
    stall_pct = 0;
    random_traffic(52);

    configure(1'b0, 16'd0);
    send_idle_pct = 0;
    stall_pct = 62;
    random_traffic(52);

    configure(1'b1, 16'hffff);
    send_idle_pct = 14;
    stall_pct = 14;
    random_traffic(52);

    configure(1'b0, 16'hffff);
    send_idle_pct = 0;
    stall_pct = 0;
    stim_us = 48'hffff_ffff_f000;
    random_traffic(52);

    configure(1'b1, 16'd0);
    send_idle_pct = 62;
    stall_pct = 0;
    // A held poll released by an overflowing frame: the longest burst of results.
    send_single(make_poll(), stim_us);
    for (int i = 0; i < FRAME_WORDS + 2; i++) begin
      send_request(CMD_WORD, any_line_word(), stim_us);
    end
    send_request(CMD_WORD, END_MARK, stim_us);
    random_traffic(40);

    configure(1'($urandom), 16'($urandom));
    send_idle_pct = 0;
    stall_pct = 62;
    random_traffic(52);

    drain();
    $display("Sent %0d requests across six register settings and four idle patterns.",
             requests_sent);
    $display("Checked %0d results: %0d idle-poll events, %0d frames cut by overflow.",
             results_seen, idle_events, cut_frames);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== coax_frame_assembler_poll_filter_core.f =====
hdl/cfa_pkg.sv
hdl/cfa_queue.sv
hdl/cfa_front.sv
hdl/cfa_back.sv
hdl/coax_frame_assembler_poll_filter_core.sv
dv/cfa_frame_check.sv
dv/tb.sv
